[hdl/stt_pkg.sv]
// ============================================================================
// stt_pkg: shared definitions for the soft timer table
// Command and status codes, field widths, parameter defaults and the
// control/status structs between the controller and the datapath.
// ============================================================================
package stt_pkg;

    localparam int CMD_W     = 2;
    localparam int TASK_W    = 3;
    localparam int NUM_TASKS = 8;
    localparam int TIME_W    = 16;
    localparam int STAT_W    = 2;

    localparam int NUM_SLOTS_DEF  = 8;
    localparam int COUNT_BITS_DEF = 16;

    localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ACK  = 2'd2;

    localparam logic [STAT_W-1:0] STAT_DONE     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RELOADED = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NEW_SLOT = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NO_FREE  = 2'd3;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic start;   // capture the accepted item, rewind the slot scan
        logic issue;   // read the slot under the scan index, advance it
        logic finish;  // apply the tick/set/ack update and load the result
    } stt_ctl_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic last_slot;  // scan index sits on the last slot
    } stt_sts_t;

endpackage

[hdl/soft_timer_table.sv]
// ============================================================================
// soft_timer_table: table of one-shot task timers with expiry flags
// Set, tick and acknowledge items on one stream; one result item each.
// ============================================================================
//
// channel  dir  signals                          item
// s_       in   s_tvalid s_tready s_tdata s_tuser  command with task and time
// m_       out  m_tvalid m_tready m_tdata          pending flags, fired, status
//
// Each item runs through idle, which takes the item, a scan that walks the
// slot memory one slot per cycle through its single read port, a drain step
// that processes the last slot and a done step that writes back and loads the
// result; only then does the block return to idle for the next item. Reset
// empties every slot and clears all pending flags at once. A stalled result
// holds in the output register; the block takes the next item meanwhile and
// waits at the end of it until the register frees.
//
module soft_timer_table #(
    parameter int NUM_SLOTS  = stt_pkg::NUM_SLOTS_DEF,
    parameter int COUNT_BITS = stt_pkg::COUNT_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [2:0] task_id, [18:3] time_value, [23:19] zero
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [7:0] pending_flags, [15:8] fired_mask,
                                   // [17:16] status, [23:18] zero
);
    import stt_pkg::*;

    stt_ctl_t             ctl;
    stt_sts_t             sts;
    logic [NUM_TASKS-1:0] pending_flags;
    logic [NUM_TASKS-1:0] fired_mask;
    logic [STAT_W-1:0]    status;

    stt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .ctl      (ctl),
        .sts      (sts)
    );

    stt_dp #(
        .NUM_SLOTS  (NUM_SLOTS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .sts           (sts),
        .in_cmd        (s_tuser),
        .in_task_id    (s_tdata[2:0]),
        .in_time_value (s_tdata[18:3]),
        .pending_flags (pending_flags),
        .fired_mask    (fired_mask),
        .status        (status)
    );

    assign m_tdata = {6'd0, status, fired_mask, pending_flags};

endmodule

[hdl/stt_ctrl.sv]
// ============================================================================
// stt_ctrl: sequencer of the soft timer table
// Accepts one item, steps the datapath through every slot, then loads the
// result into the output register once it is free.
// ============================================================================
module stt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output stt_pkg::stt_ctl_t ctl,
    input  stt_pkg::stt_sts_t sts
);
    import stt_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_vld_reg;
    logic   out_vld_next;
    logic   out_free;

    assign out_free = !out_vld_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_vld_reg;

    always_comb
    begin
        ctl.start  = (state_reg == ST_IDLE) && s_tvalid;
        ctl.issue  = (state_reg == ST_SCAN);
        ctl.finish = (state_reg == ST_DONE) && out_free;
    end

    always_comb
    begin
        state_next   = state_reg;
        out_vld_next = out_vld_reg && !m_tready;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (sts.last_slot)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_vld_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
        end
    end

    a_rise_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(state_reg == ST_DONE))
        else $error("result valid rose outside the done step");

    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_vld_reg && !m_tready) |=> state_reg == ST_DONE)
        else $error("done step left while the output register was full");

    a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && sts.last_slot) |=> state_reg == ST_DRAIN)
        else $error("scan ran past the last slot");

endmodule

[hdl/stt_dp.sv]
// ============================================================================
// stt_dp: slot table datapath of the soft timer table
// Slot memory (task, count), valid bits and pending flags. Slots are read
// one per cycle; each read entry is processed in the cycle after its read.
// ============================================================================
module stt_dp #(
    parameter int NUM_SLOTS  = stt_pkg::NUM_SLOTS_DEF,
    parameter int COUNT_BITS = stt_pkg::COUNT_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  stt_pkg::stt_ctl_t           ctl,
    output stt_pkg::stt_sts_t           sts,
    input  logic [stt_pkg::CMD_W-1:0]   in_cmd,
    input  logic [stt_pkg::TASK_W-1:0]  in_task_id,
    input  logic [stt_pkg::TIME_W-1:0]  in_time_value,
    output logic [stt_pkg::NUM_TASKS-1:0] pending_flags,
    output logic [stt_pkg::NUM_TASKS-1:0] fired_mask,
    output logic [stt_pkg::STAT_W-1:0]  status
);
    import stt_pkg::*;

    localparam int IDX_W   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int ENTRY_W = TASK_W + COUNT_BITS;
    localparam logic [32:0] CNT_MAX = (33'd1 << COUNT_BITS) - 33'd1;

    logic [ENTRY_W-1:0]    mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]  valid_reg;
    logic [NUM_TASKS-1:0]  pending_reg;

    logic [CMD_W-1:0]      cmd_reg;
    logic [TASK_W-1:0]     task_reg;
    logic [COUNT_BITS-1:0] cnt_reg;
    logic [COUNT_BITS-1:0] cnt_sat;
    logic [32:0]           time_ext;

    logic [IDX_W-1:0]      idx_reg;
    logic [IDX_W-1:0]      proc_idx_reg;
    logic                  proc_vld_reg;
    logic [ENTRY_W-1:0]    rd_data_reg;
    logic [TASK_W-1:0]     rd_task;
    logic [COUNT_BITS-1:0] rd_cnt;
    logic                  rd_active;

    logic                  match_reg;
    logic [IDX_W-1:0]      match_idx_reg;
    logic                  free_reg;
    logic [IDX_W-1:0]      free_idx_reg;
    logic [NUM_TASKS-1:0]  fired_acc_reg;

    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [ENTRY_W-1:0]    mem_wdata;
    logic                  tick_dec;
    logic                  tick_fire;
    logic                  set_hit;
    logic                  set_free;

    logic [NUM_TASKS-1:0]  pending_final;
    logic [STAT_W-1:0]     status_final;

    // Saturate the loaded count when the counter is narrower than the field
    assign time_ext = 33'(in_time_value);
    assign cnt_sat  = (time_ext > CNT_MAX) ? CNT_MAX[COUNT_BITS-1:0]
                                           : time_ext[COUNT_BITS-1:0];

    assign sts.last_slot = (idx_reg == IDX_W'(NUM_SLOTS - 1));

    assign rd_task   = rd_data_reg[ENTRY_W-1:COUNT_BITS];
    assign rd_cnt    = rd_data_reg[COUNT_BITS-1:0];
    assign rd_active = valid_reg[proc_idx_reg];

    assign tick_dec  = proc_vld_reg && (cmd_reg == CMD_TICK) && rd_active && (rd_cnt != '0);
    assign tick_fire = proc_vld_reg && (cmd_reg == CMD_TICK) && rd_active && (rd_cnt == '0);
    assign set_hit   = proc_vld_reg && (cmd_reg == CMD_SET) && rd_active && (rd_task == task_reg);
    assign set_free  = proc_vld_reg && (cmd_reg == CMD_SET) && !rd_active && !free_reg;

    always_comb
    begin
        mem_we    = tick_dec;
        mem_waddr = proc_idx_reg;
        mem_wdata = {rd_task, rd_cnt - COUNT_BITS'(1)};
        if (ctl.finish && (cmd_reg == CMD_SET) && (match_reg || free_reg))
        begin
            mem_we    = 1'b1;
            mem_waddr = match_reg ? match_idx_reg : free_idx_reg;
            mem_wdata = {task_reg, cnt_reg};
        end
    end

    always_comb
    begin
        pending_final = pending_reg;
        status_final  = STAT_DONE;
        case (cmd_reg)
            CMD_TICK:
            begin
                pending_final = pending_reg | fired_acc_reg;
            end
            CMD_SET:
            begin
                if (match_reg)
                    status_final = STAT_RELOADED;
                else if (free_reg)
                    status_final = STAT_NEW_SLOT;
                else
                    status_final = STAT_NO_FREE;
            end
            CMD_ACK:
            begin
                pending_final = pending_reg & ~(NUM_TASKS'(1) << task_reg);
            end
            default:
            begin
                pending_final = pending_reg;
            end
        endcase
    end

    // Slot memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (ctl.issue)
            rd_data_reg <= mem[idx_reg];
    end

    // Item capture and result payload
    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            cmd_reg  <= in_cmd;
            task_reg <= in_task_id;
            cnt_reg  <= cnt_sat;
        end
        if (set_hit)
            match_idx_reg <= proc_idx_reg;
        if (set_free)
            free_idx_reg <= proc_idx_reg;
        if (ctl.issue)
            proc_idx_reg <= idx_reg;
        if (ctl.finish)
        begin
            fired_mask <= fired_acc_reg;
            status     <= status_final;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            pending_reg   <= '0;
            idx_reg       <= '0;
            proc_vld_reg  <= 1'b0;
            match_reg     <= 1'b0;
            free_reg      <= 1'b0;
            fired_acc_reg <= '0;
        end
        else
        begin
            proc_vld_reg <= ctl.issue;
            if (ctl.start)
            begin
                idx_reg       <= '0;
                match_reg     <= 1'b0;
                free_reg      <= 1'b0;
                fired_acc_reg <= '0;
            end
            else if (ctl.issue)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            if (set_hit)
                match_reg <= 1'b1;
            if (set_free)
                free_reg <= 1'b1;
            // Expire: flag the task and drop the slot
            if (tick_fire)
            begin
                fired_acc_reg           <= fired_acc_reg | (NUM_TASKS'(1) << rd_task);
                valid_reg[proc_idx_reg] <= 1'b0;
            end
            if (ctl.finish)
            begin
                pending_reg <= pending_final;
                if ((cmd_reg == CMD_SET) && !match_reg && free_reg)
                    valid_reg[free_idx_reg] <= 1'b1;
            end
        end
    end

    assign pending_flags = pending_reg;

    a_fired_tick_only: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.finish && cmd_reg != CMD_TICK) |-> fired_acc_reg == '0)
        else $error("fired tasks collected for a non-tick item");

    a_no_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.finish |-> !proc_vld_reg)
        else $error("set write overlaps slot processing");

    a_proc_follows_issue: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.issue |=> proc_vld_reg && proc_idx_reg == $past(idx_reg))
        else $error("processed slot differs from the slot read");

endmodule
